// ===== src/ptc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ptc_pkg;

  // Field widths
  localparam int RAW_W  = 24;
  localparam int CAL_W  = 16;
  localparam int TEMP_W = 19;
  localparam int PRES_W = 23;

  // Configuration port geometry
  localparam int APB_DW = 32;
  localparam int APB_AW = 5;
  localparam int IDX_W  = 3;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_PRESSURE_SENSITIVITY  = 3'd0;
  localparam logic [IDX_W-1:0] REG_PRESSURE_OFFSET       = 3'd1;
  localparam logic [IDX_W-1:0] REG_SENSITIVITY_TEMP_COEF = 3'd2;
  localparam logic [IDX_W-1:0] REG_OFFSET_TEMP_COEF      = 3'd3;
  localparam logic [IDX_W-1:0] REG_REFERENCE_TEMP        = 3'd4;
  localparam logic [IDX_W-1:0] REG_TEMP_COEF             = 3'd5;

  // Compensation constants
  localparam int TEMP_BASE    = 2000;
  localparam int TEMP_LOW_OFS = 3500;   // distance from 20.00 C down to -15.00 C
  localparam logic [PRES_W-1:0] P_MAX = {PRES_W{1'b1}};

  typedef struct packed {
    logic [CAL_W-1:0] pressure_sensitivity;
    logic [CAL_W-1:0] pressure_offset;
    logic [CAL_W-1:0] sensitivity_temp_coef;
    logic [CAL_W-1:0] offset_temp_coef;
    logic [CAL_W-1:0] reference_temp;
    logic [CAL_W-1:0] temp_coef;
  } ptc_cal_t;

  // Request handed from the temperature front end to the pressure back end
  typedef struct packed {
    logic [RAW_W-1:0]         d1;
    logic                     cold;    // TEMP below 20.00 C
    logic                     vlow;    // TEMP below -15.00 C
    logic signed [TEMP_W-1:0] t_out;
    logic [34:0]              dev;     // (TEMP-2000)^2
    logic [34:0]              low;     // (TEMP+1500)^2, meaningful when vlow
    logic signed [34:0]       sens;
    logic signed [35:0]       off;
  } ptc_mid_t;

endpackage
`default_nettype wire

// ===== src/ptc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface ptc_in_if;
  import ptc_pkg::*;
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_pressure;
  logic [RAW_W-1:0] raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface ptc_out_if;
  import ptc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_centideg;
  logic [PRES_W-1:0]        pressure_value;

  modport source (output valid, output temperature_centideg, output pressure_value,
                  input ready);
  modport sink (input valid, input temperature_centideg, input pressure_value,
                output ready);
endinterface
`default_nettype wire

// ===== src/ptc_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ptc_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ptc_pkg::APB_AW-1:0] paddr,
  input  wire logic [ptc_pkg::APB_DW-1:0] pwdata,
  output logic      [ptc_pkg::APB_DW-1:0] prdata,
  output logic                            pready,
  output ptc_pkg::ptc_cal_t               cal
);
  import ptc_pkg::*;

  ptc_cal_t         cal_r, cal_nxt;
  logic [IDX_W-1:0] idx;
  logic             wr_en;
  logic [CAL_W-1:0] rd_word;

  assign idx    = paddr[APB_AW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cal    = cal_r;

  // Decode the write; drop writes past the last register
  always_comb begin
    cal_nxt = cal_r;
    if (wr_en) begin
      case (idx)
        REG_PRESSURE_SENSITIVITY:  cal_nxt.pressure_sensitivity  = pwdata[CAL_W-1:0];
        REG_PRESSURE_OFFSET:       cal_nxt.pressure_offset       = pwdata[CAL_W-1:0];
        REG_SENSITIVITY_TEMP_COEF: cal_nxt.sensitivity_temp_coef = pwdata[CAL_W-1:0];
        REG_OFFSET_TEMP_COEF:      cal_nxt.offset_temp_coef      = pwdata[CAL_W-1:0];
        REG_REFERENCE_TEMP:        cal_nxt.reference_temp        = pwdata[CAL_W-1:0];
        REG_TEMP_COEF:             cal_nxt.temp_coef             = pwdata[CAL_W-1:0];
        default:                   cal_nxt = cal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_PRESSURE_SENSITIVITY:  rd_word = cal_r.pressure_sensitivity;
      REG_PRESSURE_OFFSET:       rd_word = cal_r.pressure_offset;
      REG_SENSITIVITY_TEMP_COEF: rd_word = cal_r.sensitivity_temp_coef;
      REG_OFFSET_TEMP_COEF:      rd_word = cal_r.offset_temp_coef;
      REG_REFERENCE_TEMP:        rd_word = cal_r.reference_temp;
      REG_TEMP_COEF:             rd_word = cal_r.temp_coef;
      default:                   rd_word = '0;
    endcase
  end

  assign prdata = {{(APB_DW-CAL_W){1'b0}}, rd_word};

endmodule
`default_nettype wire

// ===== src/ptc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ptc_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [ptc_pkg::RAW_W-1:0] d1,
  input  wire logic [ptc_pkg::RAW_W-1:0] d2,
  input  wire ptc_pkg::ptc_cal_t         cal,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output ptc_pkg::ptc_mid_t              out_data
);
  import ptc_pkg::*;

  // Stage valid bits and ready chain
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // Stage 1: dT = D2 - C5*256
  logic [RAW_W-1:0]   d1_1_r;
  logic signed [24:0] dt_r, dt_nxt;

  assign dt_nxt = $signed({1'b0, d2}) - $signed({1'b0, cal.reference_temp, 8'h00});

  always_ff @(posedge clk) begin
    if (rdy1) begin
      d1_1_r <= d1;
      dt_r   <= dt_nxt;
    end
  end

  // Stage 2: products of dT
  logic [RAW_W-1:0]   d1_2_r;
  logic signed [41:0] pt_r, ps_r, po_r, pt_nxt, ps_nxt, po_nxt;
  logic signed [49:0] sq_dt;
  logic [48:0]        dd_r;

  assign pt_nxt = 42'(dt_r) * 42'($signed({1'b0, cal.temp_coef}));
  assign ps_nxt = 42'(dt_r) * 42'($signed({1'b0, cal.sensitivity_temp_coef}));
  assign po_nxt = 42'(dt_r) * 42'($signed({1'b0, cal.offset_temp_coef}));
  assign sq_dt  = 50'(dt_r) * 50'(dt_r);

  always_ff @(posedge clk) begin
    if (rdy2) begin
      d1_2_r <= d1_1_r;
      pt_r   <= pt_nxt;
      ps_r   <= ps_nxt;
      po_r   <= po_nxt;
      dd_r   <= sq_dt[48:0];
    end
  end

  // Stage 3: TEMP offset, SENS, OFF and the temperature correction Ti
  logic [RAW_W-1:0]   d1_3_r;
  logic signed [17:0] tq_r;
  logic signed [34:0] sens_r, sens_nxt;
  logic signed [35:0] off_r, off_nxt;
  logic [17:0]        ti_r, ti_nxt;
  logic               cold_r;
  logic [50:0]        dd3;

  assign sens_nxt = 35'($signed({1'b0, cal.pressure_sensitivity, 16'h0000}))
                  + 35'($signed(ps_r[40:7]));
  assign off_nxt  = 36'($signed({1'b0, cal.pressure_offset, 17'h00000}))
                  + 36'($signed(po_r[40:6]));
  assign dd3      = {2'b00, dd_r} + {1'b0, dd_r, 1'b0};
  assign ti_nxt   = pt_r[40] ? dd3[50:33] : {5'b00000, dd_r[48:36]};

  always_ff @(posedge clk) begin
    if (rdy3) begin
      d1_3_r <= d1_2_r;
      tq_r   <= $signed(pt_r[40:23]);
      cold_r <= pt_r[40];
      sens_r <= sens_nxt;
      off_r  <= off_nxt;
      ti_r   <= ti_nxt;
    end
  end

  // Stage 4: squared deviations and final temperature
  logic signed [35:0]       sq_dev;
  logic signed [18:0]       tl;
  logic signed [37:0]       sq_low;
  logic signed [TEMP_W-1:0] t_nxt;
  ptc_mid_t                 mid_r;

  assign sq_dev = 36'(tq_r) * 36'(tq_r);
  assign tl     = 19'(tq_r) + 19'(TEMP_LOW_OFS);
  assign sq_low = 38'(tl) * 38'(tl);
  assign t_nxt  = 19'(tq_r) + 19'(TEMP_BASE) - $signed({1'b0, ti_r});

  always_ff @(posedge clk) begin
    if (rdy4) begin
      mid_r.d1    <= d1_3_r;
      mid_r.cold  <= cold_r;
      mid_r.vlow  <= tl[18];
      mid_r.t_out <= t_nxt;
      mid_r.dev   <= sq_dev[34:0];
      mid_r.low   <= sq_low[34:0];
      mid_r.sens  <= sens_r;
      mid_r.off   <= off_r;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = mid_r;

endmodule
`default_nettype wire

// ===== src/ptc_press.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ptc_press (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire ptc_pkg::ptc_mid_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [ptc_pkg::TEMP_W-1:0]      out_temp,
  output logic        [ptc_pkg::PRES_W-1:0]      out_pres
);
  import ptc_pkg::*;

  // Stage valid bits and ready chain
  logic v5_r, v6_r, v7_r, v8_r, v9_r;
  logic rdy5, rdy6, rdy7, rdy8, rdy9;

  assign rdy9     = !v9_r || out_ready;
  assign rdy8     = !v8_r || rdy9;
  assign rdy7     = !v7_r || rdy8;
  assign rdy6     = !v6_r || rdy7;
  assign rdy5     = !v5_r || rdy6;
  assign in_ready = rdy5;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      v9_r <= 1'b0;
    end else begin
      if (rdy5) v5_r <= in_valid;
      if (rdy6) v6_r <= v5_r;
      if (rdy7) v7_r <= v6_r;
      if (rdy8) v8_r <= v7_r;
      if (rdy9) v9_r <= v8_r;
    end
  end

  // Stage 5: second-order offset and sensitivity terms
  logic [35:0]              dev3;
  logic [36:0]              dev5;
  logic [37:0]              low7;
  logic [36:0]              low4;
  logic [37:0]              offi_nxt, offi_r;
  logic [36:0]              sensi_nxt, sensi_r;
  logic [RAW_W-1:0]         d1_5_r;
  logic signed [TEMP_W-1:0] t5_r;
  logic signed [34:0]       sens5_r;
  logic signed [35:0]       off5_r;

  assign dev3 = {in_data.dev, 1'b0} + {1'b0, in_data.dev};
  assign dev5 = {in_data.dev, 2'b00} + {2'b00, in_data.dev};
  assign low7 = {in_data.low, 3'b000} - {3'b000, in_data.low};
  assign low4 = {in_data.low, 2'b00};

  always_comb begin
    if (!in_data.cold) begin
      offi_nxt  = {7'd0, in_data.dev[34:4]};
      sensi_nxt = '0;
    end else if (in_data.vlow) begin
      offi_nxt  = {3'b000, dev3[35:1]} + low7;
      sensi_nxt = {3'b000, dev5[36:3]} + low4;
    end else begin
      offi_nxt  = {3'b000, dev3[35:1]};
      sensi_nxt = {3'b000, dev5[36:3]};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      offi_r  <= offi_nxt;
      sensi_r <= sensi_nxt;
      d1_5_r  <= in_data.d1;
      t5_r    <= in_data.t_out;
      sens5_r <= in_data.sens;
      off5_r  <= in_data.off;
    end
  end

  // Stage 6: corrected SENS and OFF
  logic signed [38:0]       diff_r;
  logic signed [39:0]       offn6_r;
  logic [RAW_W-1:0]         d1_6_r;
  logic signed [TEMP_W-1:0] t6_r;

  always_ff @(posedge clk) begin
    if (rdy6) begin
      diff_r  <= 39'(sens5_r) - $signed({2'b00, sensi_r});
      offn6_r <= 40'(off5_r) - $signed({2'b00, offi_r});
      d1_6_r  <= d1_5_r;
      t6_r    <= t5_r;
    end
  end

  // Stage 7: D1 * SENS as two partial products
  logic [43:0]              pl_r;
  logic signed [43:0]       ph_r;
  logic signed [39:0]       offn7_r;
  logic signed [TEMP_W-1:0] t7_r;

  always_ff @(posedge clk) begin
    if (rdy7) begin
      pl_r    <= 44'(d1_6_r) * 44'(diff_r[19:0]);
      ph_r    <= 44'($signed({1'b0, d1_6_r})) * 44'($signed(diff_r[38:20]));
      offn7_r <= offn6_r;
      t7_r    <= t6_r;
    end
  end

  // Stage 8: merge the partial products
  logic signed [63:0]       prod_r;
  logic signed [39:0]       offn8_r;
  logic signed [TEMP_W-1:0] t8_r;

  always_ff @(posedge clk) begin
    if (rdy8) begin
      prod_r  <= $signed({ph_r, 20'h00000} + {20'h00000, pl_r});
      offn8_r <= offn7_r;
      t8_r    <= t7_r;
    end
  end

  // Stage 9: subtract offset, scale, saturate into the output register
  logic signed [43:0]       q;
  logic [28:0]              p;
  logic [PRES_W-1:0]        pres_nxt, pres_r;
  logic signed [TEMP_W-1:0] t9_r;

  assign q = 44'($signed(prod_r[63:21])) - 44'(offn8_r);
  assign p = q[43:15];

  always_comb begin
    if (p[28]) begin
      pres_nxt = '0;
    end else if (p[27:PRES_W] != '0) begin
      pres_nxt = P_MAX;
    end else begin
      pres_nxt = p[PRES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy9) begin
      pres_r <= pres_nxt;
      t9_r   <= t8_r;
    end
  end

  assign out_valid = v9_r;
  assign out_temp  = t9_r;
  assign out_pres  = pres_r;

endmodule
`default_nettype wire

// ===== src/pressure_temp_compensation.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Second-order barometric compensation. Each request carries one raw pressure
// (D1) and one raw temperature (D2) conversion and yields one result: the
// compensated temperature in hundredths of a degree Celsius and the compensated
// pressure, clamped to 0 and to the 23-bit maximum. Load the six calibration
// words over the APB port (register i at byte address 4*i) while no request is
// in flight. The datapath is a nine-stage pipeline: a new request is taken
// every cycle while no stall has backed up to the input, and each request
// passes through the front stages and then the pressure stages in order. A
// stall holds every occupied stage in place and empty stages keep filling,
// so requests are still taken while a finished result waits.
module pressure_temp_compensation (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  ptc_in_if.sink                          in_ch,
  ptc_out_if.source                       out_ch,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ptc_pkg::APB_AW-1:0] paddr,
  input  wire logic [ptc_pkg::APB_DW-1:0] pwdata,
  output logic      [ptc_pkg::APB_DW-1:0] prdata,
  output logic                            pready
);
  import ptc_pkg::*;

  ptc_cal_t cal;
  ptc_mid_t mid_data;
  logic     mid_valid;
  logic     mid_ready;

  // Calibration registers
  ptc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cal     (cal)
  );

  // Temperature, SENS and OFF
  ptc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .d1        (in_ch.raw_pressure),
    .d2        (in_ch.raw_temperature),
    .cal       (cal),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_data  (mid_data)
  );

  // Second-order correction and pressure
  ptc_press u_press (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_data   (mid_data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_temp  (out_ch.temperature_centideg),
    .out_pres  (out_ch.pressure_value)
  );

  // A free result side frees every stage back to the input
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input stalled while result side is ready");

  // An empty output register means the pipeline can advance
  a_empty_out: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output stage");

  // A stalled request between front and back end holds
  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    mid_valid && !mid_ready |=> mid_valid && $stable(mid_data))
    else $error("mid-pipeline request lost or changed under stall");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import ptc_pkg::*;

  localparam int CYCLE_LIMIT      = 500000;
  localparam int RX_FREEZE_CYCLES = 300;
  localparam int RANDOM_PHASES    = 8;
  localparam int PHASE_ITEMS      = 215;
  localparam int TEMP_VERY_LOW    = TEMP_BASE - TEMP_LOW_OFS;

  // Indexes past the last calibration word; writes there must be dropped
  localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;
  } conv_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature_centideg;
    logic [PRES_W-1:0]        pressure_value;
  } reading_t;

  logic clk;
  logic rst_n = 1'b0;

  // Request side
  logic             src_valid = 1'b0;
  logic [RAW_W-1:0] src_press = '0;
  logic [RAW_W-1:0] src_temp  = '0;
  logic             sink_ready = 1'b0;

  // APB side
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr   = '0;
  logic [APB_DW-1:0] pwdata  = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  ptc_in_if  in_bus ();
  ptc_out_if out_bus ();

  assign in_bus.valid           = src_valid;
  assign in_bus.raw_pressure    = src_press;
  assign in_bus.raw_temperature = src_temp;
  assign out_bus.ready          = sink_ready;

  pressure_temp_compensation uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ptc_cal_t    cal_model = '0;
  conv_t       pending_conversions[$];
  reading_t    expected_readings[$];
  conv_t       feed_item;
  int unsigned in_gap_max  = 0;
  int unsigned out_gap_max = 0;
  int unsigned in_wait  = 0;
  int unsigned out_wait = 0;
  int unsigned rx_pause;
  logic        in_taken  = 1'b0;
  logic        out_taken = 1'b0;
  logic        rx_frozen = 1'b0;
  int          cycle_count = 0;
  int          errors = 0;
  int          conversions_sent = 0;
  int          readings_checked = 0;
  int          cal_settings = 0;
  event        rx_freeze_ev;

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
  end

  // Second-order compensation of one conversion pair under the current calibration
  function automatic reading_t compensate(input conv_t c);
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, temp, sens, off, ti, offi, sensi, dev, low, p, t_out;
    reading_t r;
    d1 = {40'd0, c.raw_pressure};
    d2 = {40'd0, c.raw_temperature};
    c1 = {48'd0, cal_model.pressure_sensitivity};
    c2 = {48'd0, cal_model.pressure_offset};
    c3 = {48'd0, cal_model.sensitivity_temp_coef};
    c4 = {48'd0, cal_model.offset_temp_coef};
    c5 = {48'd0, cal_model.reference_temp};
    c6 = {48'd0, cal_model.temp_coef};

    // First order
    dt   = d2 - c5 * 256;
    temp = TEMP_BASE + ((dt * c6) >>> 23);
    sens = c1 * 65536 + ((c3 * dt) >>> 7);
    off  = c2 * 131072 + ((c4 * dt) >>> 6);

    // Second order, by temperature band
    dev = (temp - TEMP_BASE) * (temp - TEMP_BASE);
    if (temp < TEMP_BASE) begin
      ti    = (3 * dt * dt) >>> 33;
      offi  = (3 * dev) >>> 1;
      sensi = (5 * dev) >>> 3;
      if (temp < TEMP_VERY_LOW) begin
        low   = (temp - TEMP_VERY_LOW) * (temp - TEMP_VERY_LOW);
        offi  = offi + 7 * low;
        sensi = sensi + 4 * low;
      end
    end else begin
      ti    = (2 * dt * dt) >>> 37;
      offi  = dev >>> 4;
      sensi = 0;
    end

    p = (((d1 * (sens - sensi)) >>> 21) - (off - offi)) >>> 15;
    if (p < 0) p = 0;
    if (p > longint'(P_MAX)) p = longint'(P_MAX);

    t_out = temp - ti;
    r.temperature_centideg = t_out[TEMP_W-1:0];
    r.pressure_value       = p[PRES_W-1:0];
    return r;
  endfunction

  function automatic logic [CAL_W-1:0] random_word();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return r[CAL_W-1:0];
    endcase
  endfunction

  // Random conversion, often aimed at the band edges of the current calibration
  function automatic conv_t pick_conversion();
    conv_t  c;
    logic [31:0] r1, r2;
    longint ref_pt, c6, tgt, span;
    bit     aimed;
    r1 = $urandom;
    r2 = $urandom;
    c.raw_pressure    = r1[RAW_W-1:0];
    c.raw_temperature = r2[RAW_W-1:0];
    case ($urandom_range(0, 7))
      0: c.raw_pressure = '0;
      1: c.raw_pressure = '1;
      default: ;
    endcase
    ref_pt = {48'd0, cal_model.reference_temp};
    ref_pt = ref_pt * 256;
    c6     = {48'd0, cal_model.temp_coef};
    aimed  = 1'b0;
    tgt    = 0;
    case ($urandom_range(0, 9))
      // around 20.00 C
      3, 4: begin
        tgt   = $urandom_range(0, 2048);
        tgt   = ref_pt + tgt - 1024;
        aimed = 1'b1;
      end
      // around -15.00 C
      5, 6: begin
        if (c6 != 0) begin
          span  = 64'sd33554432 / c6 + 16;
          tgt   = $urandom_range(0, 32'(2 * span));
          tgt   = ref_pt - (longint'(TEMP_LOW_OFS) * 8388608) / c6 + tgt - span;
          aimed = 1'b1;
        end
      end
      7: begin
        tgt   = ($urandom_range(0, 1) != 0) ? 64'sd16777215 : 64'sd0;
        aimed = 1'b1;
      end
      8, 9: begin
        tgt   = $urandom_range(0, 2097152);
        tgt   = ref_pt + tgt - 1048576;
        aimed = 1'b1;
      end
      default: ;
    endcase
    if (aimed) begin
      if (tgt < 0) tgt = 0;
      if (tgt > 64'sd16777215) tgt = 64'sd16777215;
      c.raw_temperature = tgt[RAW_W-1:0];
    end
    return c;
  endfunction

  // Check results against the oldest expectation, then record new requests
  always @(posedge clk) begin
    reading_t want, got;
    cycle_count <= cycle_count + 1;
    in_taken    <= in_bus.valid && in_bus.ready;
    out_taken   <= out_bus.valid && out_bus.ready;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        got.temperature_centideg = out_bus.temperature_centideg;
        got.pressure_value       = out_bus.pressure_value;
        if (expected_readings.size() == 0) begin
          $error("unexpected reading: temperature_centideg %0d, pressure_value %0d",
                 got.temperature_centideg, got.pressure_value);
          errors++;
        end else begin
          want = expected_readings.pop_front();
          readings_checked++;
          if (got.temperature_centideg !== want.temperature_centideg) begin
            $error("temperature_centideg: expected %0d, got %0d",
                   want.temperature_centideg, got.temperature_centideg);
            errors++;
          end
          if (got.pressure_value !== want.pressure_value) begin
            $error("pressure_value: expected %0d, got %0d",
                   want.pressure_value, got.pressure_value);
            errors++;
          end
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        feed_item.raw_pressure    = in_bus.raw_pressure;
        feed_item.raw_temperature = in_bus.raw_temperature;
        expected_readings.push_back(compensate(feed_item));
        conversions_sent++;
      end
    end
  end

  // Offer the next conversion once the current request has been taken
  always @(negedge clk) begin
    conv_t nxt;
    if (!rst_n) begin
      src_valid <= 1'b0;
      in_wait   <= 0;
    end else if (!src_valid || in_taken) begin
      if (in_wait > 0) begin
        src_valid <= 1'b0;
        in_wait   <= in_wait - 1;
      end else if (pending_conversions.size() != 0) begin
        nxt = pending_conversions.pop_front();
        src_press <= nxt.raw_pressure;
        src_temp  <= nxt.raw_temperature;
        src_valid <= 1'b1;
        in_wait   <= $urandom_range(0, in_gap_max);
      end else begin
        src_valid <= 1'b0;
      end
    end
  end

  // Drop ready for a random stretch after each reading, or while frozen
  always @(negedge clk) begin
    if (!rst_n) begin
      sink_ready <= 1'b0;
      out_wait   <= 0;
    end else if (rx_frozen) begin
      sink_ready <= 1'b0;
    end else if (out_taken) begin
      rx_pause = $urandom_range(0, out_gap_max);
      out_wait   <= rx_pause;
      sink_ready <= (rx_pause == 0);
    end else if (out_wait > 0) begin
      out_wait   <= out_wait - 1;
      sink_ready <= (out_wait == 1);
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // Long receiver hold-off so the pipeline fills and backs up the input
  initial begin
    forever begin
      @(rx_freeze_ev);
      @(negedge clk);
      rx_frozen <= 1'b1;
      repeat (RX_FREEZE_CYCLES) @(negedge clk);
      rx_frozen <= 1'b0;
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d readings outstanding",
             cycle_count, expected_readings.size());
    $display("testbench: FAIL");
    $finish;
  end

  // One APB write: setup cycle, then access cycle
  task automatic cal_write(input logic [IDX_W-1:0] idx, input logic [CAL_W-1:0] word);
    logic [31:0] junk;
    junk = $urandom;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk[APB_DW-CAL_W-1:0], word};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_PRESSURE_SENSITIVITY:  cal_model.pressure_sensitivity  = word;
      REG_PRESSURE_OFFSET:       cal_model.pressure_offset       = word;
      REG_SENSITIVITY_TEMP_COEF: cal_model.sensitivity_temp_coef = word;
      REG_OFFSET_TEMP_COEF:      cal_model.offset_temp_coef      = word;
      REG_REFERENCE_TEMP:        cal_model.reference_temp        = word;
      REG_TEMP_COEF:             cal_model.temp_coef             = word;
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_cal(input ptc_cal_t c);
    cal_write(REG_PRESSURE_SENSITIVITY,  c.pressure_sensitivity);
    cal_write(REG_PRESSURE_OFFSET,       c.pressure_offset);
    cal_write(REG_SENSITIVITY_TEMP_COEF, c.sensitivity_temp_coef);
    cal_write(REG_OFFSET_TEMP_COEF,      c.offset_temp_coef);
    cal_write(REG_REFERENCE_TEMP,        c.reference_temp);
    cal_write(REG_TEMP_COEF,             c.temp_coef);
    cal_settings++;
  endtask

  // Hold until every conversion is taken and every reading has come back
  task automatic drain();
    while (pending_conversions.size() != 0 || src_valid || expected_readings.size() != 0)
      @(posedge clk);
  endtask

  task automatic add_conv(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
    conv_t c;
    c.raw_pressure    = d1;
    c.raw_temperature = d2;
    pending_conversions.push_back(c);
  endtask

  task automatic set_gaps(input int unsigned gin, input int unsigned gout);
    @(posedge clk);
    in_gap_max  = gin;
    out_gap_max = gout;
  endtask

  // Stimulus
  initial begin
    ptc_cal_t cfg;
    logic [31:0] r;
    int unsigned gin_tab[RANDOM_PHASES];
    int unsigned gout_tab[RANDOM_PHASES];
    gin_tab  = '{0, 17, 0, 17, 4, 0, 17, 9};
    gout_tab = '{0, 0, 17, 17, 4, 0, 8, 17};

    while (!rst_n) @(negedge clk);
    @(negedge clk);

    // Reset calibration: all words zero
    set_gaps(5, 5);
    add_conv('0, '0);
    add_conv('1, '1);
    add_conv('1, '0);
    add_conv('0, '1);
    drain();

    // Typical calibration, both spare indexes written with junk
    cfg.pressure_sensitivity  = 16'd34982;
    cfg.pressure_offset       = 16'd36352;
    cfg.sensitivity_temp_coef = 16'd20328;
    cfg.offset_temp_coef      = 16'd22354;
    cfg.reference_temp        = 16'd26646;
    cfg.temp_coef             = 16'd26146;
    load_cal(cfg);
    r = $urandom;
    cal_write(REG_SPARE_A, r[CAL_W-1:0]);
    r = $urandom;
    cal_write(REG_SPARE_B, r[31:16]);
    set_gaps(5, 5);
    add_conv(24'd4958179, 24'd6815414);
    add_conv('0, 24'd6821376);            // exactly 20.00 C
    add_conv('1, 24'd6821376);
    add_conv(24'd4958179, 24'd6821375);   // one step below 20.00 C
    add_conv(24'd4958179, '0);
    add_conv(24'd4958179, '1);
    add_conv(24'd4958179, 24'd5698000);   // just below -15.00 C
    add_conv(24'd4958179, 24'd5698800);   // just above -15.00 C
    add_conv(24'hAAAAAA, 24'h555555);
    add_conv(24'h555555, 24'hAAAAAA);
    add_conv('1, '0);
    drain();

    // All words at maximum
    load_cal('1);
    set_gaps(5, 5);
    add_conv('0, '0);
    add_conv('1, '1);
    add_conv('1, '0);
    add_conv('0, '1);
    drain();

    // Offset dominates sensitivity: pressure goes below range
    cfg = '0;
    cfg.pressure_offset  = '1;
    cfg.offset_temp_coef = '1;
    cfg.temp_coef        = '1;
    load_cal(cfg);
    set_gaps(5, 5);
    add_conv('1, '1);
    add_conv('0, '0);
    drain();

    // Random calibrations and conversions, idling varied per phase
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      cfg.pressure_sensitivity  = random_word();
      cfg.pressure_offset       = random_word();
      cfg.sensitivity_temp_coef = random_word();
      cfg.offset_temp_coef      = random_word();
      cfg.reference_temp        = random_word();
      cfg.temp_coef             = random_word();
      load_cal(cfg);
      set_gaps(gin_tab[ph], gout_tab[ph]);
      for (int i = 0; i < PHASE_ITEMS; i++)
        pending_conversions.push_back(pick_conversion());
      if (ph == 5)
        -> rx_freeze_ev;
      drain();
    end

    // Let any stray reading show up before the verdict
    repeat (20) @(negedge clk);
    $display("Sent %0d conversions across %0d calibration settings, checked %0d readings",
             conversions_sent, cal_settings, readings_checked);
    $display("Bands, saturation, stalls and a %0d-cycle receiver freeze exercised",
             RX_FREEZE_CYCLES);
    if (errors == 0 && expected_readings.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/ptc_pkg.sv
src/ptc_if.sv
src/ptc_cfg.sv
src/ptc_front.sv
src/ptc_press.sv
src/pressure_temp_compensation.sv
tb/testbench.sv
